[hdl/otpc_pkg.sv]
// Shared types, codes and helpers for the outline to path command unit.
// Depends on nothing; imported by outline_to_path_commands_unit.
package otpc_pkg;

   localparam int COORD_WIDTH = 32;

   localparam int QDEPTH     = 4;
   localparam int QPTR_WIDTH = $clog2(QDEPTH);

   localparam logic [1:0] TAG_CONIC = 2'd0;
   localparam logic [1:0] TAG_ON    = 2'd1;

   localparam logic [2:0] CMD_MOVE  = 3'd0;
   localparam logic [2:0] CMD_LINE  = 3'd1;
   localparam logic [2:0] CMD_QUAD  = 3'd2;
   localparam logic [2:0] CMD_CUBIC = 3'd3;
   localparam logic [2:0] CMD_CLOSE = 3'd4;
   localparam logic [2:0] CMD_BAD   = 3'd5;

   localparam logic [2:0] REG_FLIP_VERTICAL = 3'd0;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_OPEN  = 3'd1,
      PH_CONIC = 3'd2,
      PH_CUB1  = 3'd3,
      PH_CUB2  = 3'd4
   } phase_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef logic [QPTR_WIDTH-1:0] qptr_type;
   typedef logic [QPTR_WIDTH:0]   qcount_type;

   typedef struct packed {
      coord_type  point_x;
      coord_type  point_y;
      logic [1:0] point_tag;
      logic       contour_first;
      logic       contour_end;
      logic       outline_end;
      coord_type  closing_x;
      coord_type  closing_y;
      logic [1:0] closing_tag;
   } req_type;

   typedef struct packed {
      logic [2:0] command;
      coord_type  x_one;
      coord_type  y_one;
      coord_type  x_two;
      coord_type  y_two;
      coord_type  x_three;
      coord_type  y_three;
      logic       run_last;
   } rsp_type;

   // Midpoint (a + b) / 2, truncated toward zero, sum one bit wider.
   function automatic coord_type mid_coord(input coord_type a, input coord_type b);
      logic signed [COORD_WIDTH:0] sum;
      sum = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
      sum = sum + {{COORD_WIDTH{1'b0}}, sum[COORD_WIDTH]};
      return sum[COORD_WIDTH:1];
   endfunction

   // Negate y when flipping; the most negative value saturates.
   function automatic coord_type flip_y(input coord_type y, input logic flip);
      coord_type res;
      if (!flip) begin
         res = y;
      end else if (y == {1'b1, {(COORD_WIDTH-1){1'b0}}}) begin
         res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
         res = -y;
      end
      return res;
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] cmd,
                                        input coord_type ax, input coord_type ay,
                                        input coord_type bx, input coord_type by,
                                        input coord_type cx, input coord_type cy,
                                        input logic flip);
      rsp_type r;
      r.command  = cmd;
      r.x_one    = ax;
      r.y_one    = flip_y(ay, flip);
      r.x_two    = bx;
      r.y_two    = flip_y(by, flip);
      r.x_three  = cx;
      r.y_three  = flip_y(cy, flip);
      r.run_last = 1'b0;
      return r;
   endfunction

endpackage

[hdl/outline_to_path_commands_unit.sv]
// Outline point stream to path command stream, 26.6 fixed point coordinates.
// Top level; uses otpc_pkg for payload types, command codes and helpers.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data): one outline point per item,
//    with its tag, contour marks and, on a contour's first point, the
//    contour's last point.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data): path commands, zero to two
//    per point; run_last marks the last command caused by a point.
//  - APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): register 0
//    at byte address 0 is flip_vertical (bit 0, reset 1). pready is tied high.
// Timing: a point's commands are decoded in the cycle it is accepted and
//  registered into the result queue, from which rsp is driven.
// Throughput: one point per cycle while rsp_ready is high and each gives at
//  most one command; two-command points fill the queue faster. The limit is
//  the single output port draining a four-entry result queue.
// Reset: synchronous, active high; clears the contour phase and skip flag,
//  the error latch and the queue, and sets flip_vertical.
// Stall: while rsp_ready is low, commands wait in the queue; req_ready drops
//  once fewer than two free entries remain.
module outline_to_path_commands_unit
   import otpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Contour state
   phase_type phase_ff, phase_in;
   logic      skip_ff, skip_in;
   logic      err_ff, err_in;
   coord_type start_x_ff, start_x_in, start_y_ff, start_y_in;
   coord_type ctl1_x_ff, ctl1_x_in, ctl1_y_ff, ctl1_y_in;
   coord_type ctl2_x_ff, ctl2_x_in, ctl2_y_ff, ctl2_y_in;
   logic      flip_ff;

   // Result queue
   rsp_type    queue_ff [QDEPTH];
   qptr_type   wr_ptr_ff, rd_ptr_ff;
   qcount_type count_ff, count_in;

   logic       req_fire, rsp_fire, csr_write;
   rsp_type    res [2];
   logic [1:0] push_n;
   coord_type  mid_start_x, mid_start_y, mid_ctl_x, mid_ctl_y;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign csr_write = psel && penable && pwrite && pready;

   assign pready = 1'b1;
   assign prdata = (paddr == REG_FLIP_VERTICAL) ? {31'd0, flip_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b1;
      end else if (csr_write && paddr == REG_FLIP_VERTICAL) begin
         flip_ff <= pwdata[0];
      end
   end

   assign mid_start_x = mid_coord(req_data.point_x, req_data.closing_x);
   assign mid_start_y = mid_coord(req_data.point_y, req_data.closing_y);
   assign mid_ctl_x   = mid_coord(ctl1_x_ff, req_data.point_x);
   assign mid_ctl_y   = mid_coord(ctl1_y_ff, req_data.point_y);

   // Decode one point: next contour state and up to two commands.
   always_comb begin
      logic      bad, fin, cend, is_cubic;
      coord_type px, py;
      bad        = 1'b0;
      fin        = 1'b0;
      px         = req_data.point_x;
      py         = req_data.point_y;
      cend       = req_data.contour_end || req_data.outline_end;
      is_cubic   = req_data.point_tag[1];
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      err_in     = err_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      ctl1_x_in  = ctl1_x_ff;
      ctl1_y_in  = ctl1_y_ff;
      ctl2_x_in  = ctl2_x_ff;
      ctl2_y_in  = ctl2_y_ff;
      push_n     = 2'd0;
      res[0]     = '0;
      res[1]     = '0;

      if (err_ff) begin
         // drop points until the outline ends
         if (req_data.outline_end) begin
            phase_in = PH_IDLE;
            skip_in  = 1'b0;
            err_in   = 1'b0;
         end
      end else begin
         if (req_data.contour_first) begin
            skip_in  = 1'b0;
            phase_in = PH_IDLE;
            if (is_cubic) begin
               bad = 1'b1;
            end else if (req_data.point_tag == TAG_ON) begin
               start_x_in = px;
               start_y_in = py;
               res[push_n[0]] = make_rsp(CMD_MOVE, px, py, '0, '0, '0, '0, flip_ff);
               push_n   = push_n + 2'd1;
               phase_in = PH_OPEN;
               fin      = cend;
            end else begin
               if (req_data.closing_tag == TAG_ON) begin
                  start_x_in = req_data.closing_x;
                  start_y_in = req_data.closing_y;
                  skip_in    = 1'b1;
               end else begin
                  start_x_in = mid_start_x;
                  start_y_in = mid_start_y;
               end
               res[push_n[0]] = make_rsp(CMD_MOVE, start_x_in, start_y_in,
                                         '0, '0, '0, '0, flip_ff);
               push_n = push_n + 2'd1;
               if (skip_in && cend) begin
                  phase_in = PH_OPEN;
               end else begin
                  ctl1_x_in = px;
                  ctl1_y_in = py;
                  phase_in  = PH_CONIC;
               end
               fin = cend;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (!(cend && skip_ff)) begin
               case (phase_ff)
                  PH_OPEN: begin
                     if (req_data.point_tag == TAG_ON) begin
                        res[push_n[0]] = make_rsp(CMD_LINE, px, py, '0, '0, '0, '0,
                                                  flip_ff);
                        push_n = push_n + 2'd1;
                     end else begin
                        ctl1_x_in = px;
                        ctl1_y_in = py;
                        phase_in  = is_cubic ? PH_CUB1 : PH_CONIC;
                     end
                  end
                  PH_CONIC: begin
                     if (req_data.point_tag == TAG_ON) begin
                        res[push_n[0]] = make_rsp(CMD_QUAD, ctl1_x_ff, ctl1_y_ff,
                                                  px, py, '0, '0, flip_ff);
                        push_n   = push_n + 2'd1;
                        phase_in = PH_OPEN;
                     end else if (req_data.point_tag == TAG_CONIC) begin
                        // implied on-curve point between two conic controls
                        res[push_n[0]] = make_rsp(CMD_QUAD, ctl1_x_ff, ctl1_y_ff,
                                                  mid_ctl_x, mid_ctl_y, '0, '0, flip_ff);
                        push_n    = push_n + 2'd1;
                        ctl1_x_in = px;
                        ctl1_y_in = py;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  PH_CUB1: begin
                     if (is_cubic) begin
                        ctl2_x_in = px;
                        ctl2_y_in = py;
                        phase_in  = PH_CUB2;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  PH_CUB2: begin
                     res[push_n[0]] = make_rsp(CMD_CUBIC, ctl1_x_ff, ctl1_y_ff,
                                               ctl2_x_ff, ctl2_y_ff, px, py, flip_ff);
                     push_n   = push_n + 2'd1;
                     phase_in = PH_OPEN;
                  end
                  default: begin
                  end
               endcase
            end
            fin = !bad && cend;
         end

         // close any pending curve back to the contour start
         if (fin) begin
            case (phase_in)
               PH_OPEN: begin
                  res[push_n[0]] = make_rsp(CMD_CLOSE, '0, '0, '0, '0, '0, '0, flip_ff);
                  push_n = push_n + 2'd1;
               end
               PH_CONIC: begin
                  res[push_n[0]] = make_rsp(CMD_QUAD, ctl1_x_in, ctl1_y_in,
                                            start_x_in, start_y_in, '0, '0, flip_ff);
                  push_n = push_n + 2'd1;
               end
               PH_CUB1: begin
                  bad = 1'b1;
               end
               PH_CUB2: begin
                  res[push_n[0]] = make_rsp(CMD_CUBIC, ctl1_x_in, ctl1_y_in,
                                            ctl2_x_in, ctl2_y_in,
                                            start_x_in, start_y_in, flip_ff);
                  push_n = push_n + 2'd1;
               end
               default: begin
               end
            endcase
            phase_in = PH_IDLE;
         end

         if (bad) begin
            // a malformed outline gives the error mark alone
            res[0]   = make_rsp(CMD_BAD, '0, '0, '0, '0, '0, '0, flip_ff);
            push_n   = 2'd1;
            phase_in = PH_IDLE;
            err_in   = 1'b1;
         end
         if (cend) begin
            phase_in = PH_IDLE;
         end
         if (req_data.outline_end) begin
            err_in   = 1'b0;
            phase_in = PH_IDLE;
            skip_in  = 1'b0;
         end
      end

      if (push_n == 2'd1) begin
         res[0].run_last = 1'b1;
      end
      if (push_n == 2'd2) begin
         res[1].run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         skip_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         ctl1_x_ff  <= ctl1_x_in;
         ctl1_y_ff  <= ctl1_y_in;
         ctl2_x_ff  <= ctl2_x_in;
         ctl2_y_ff  <= ctl2_y_in;
      end
   end

   // Result queue: up to two writes and one read per cycle
   assign req_ready = (count_ff <= qcount_type'(QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         count_in = count_in + qcount_type'(push_n);
      end
      if (rsp_fire) begin
         count_in = count_in - qcount_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            wr_ptr_ff <= wr_ptr_ff + qptr_type'(push_n);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + qptr_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res[0];
      end
      if (req_fire && push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + qptr_type'(1)] <= res[1];
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= qcount_type'(QDEPTH))
      else $error("result queue overflow");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (req_fire && push_n == 2'd2) |->
         (res[0].command != CMD_BAD && res[1].command != CMD_BAD))
      else $error("error mark shares a point with another command");

   a_error_idle: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> (phase_ff == PH_IDLE))
      else $error("contour open while error latched");

   a_push_drains: assert property (@(posedge clock) disable iff (reset)
      (req_fire && push_n != 2'd0) |=> rsp_valid)
      else $error("pushed command not shown");

endmodule

[tb/tb_outline_to_path_commands_unit.sv]
// Testbench for outline_to_path_commands_unit: outline points go in, path commands come out.
// It predicts every command from its own model of the block and checks each one in order.
// Depends on otpc_pkg and outline_to_path_commands_unit.
`timescale 1ns / 100ps

module tb_outline_to_path_commands_unit;
   import otpc_pkg::*;

   localparam int          CLOCK_PERIOD = 20;
   localparam int          LIMIT_CYCLES = 200000;
   localparam int          DRAIN_CYCLES = 4;
   localparam logic [1:0]  TAG_CUBIC     = 2'd2;
   localparam logic [1:0]  TAG_CUBIC_ALT = 2'd3;
   localparam coord_type   COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type   COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   outline_to_path_commands_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Decomposer model state
   coord_type start_x, start_y;
   coord_type ctl1_x, ctl1_y, ctl2_x, ctl2_y;
   phase_type phase;
   logic      skip_close;
   logic      err_latched;
   logic      flip_on;
   rsp_type   step_cmds [2];
   int        step_count;
   logic      step_bad;

   rsp_type   expected_cmds [$];
   rsp_type   want_cmd;
   int        fail_count = 0;
   int        cycle_count = 0;
   int        sent_points = 0;
   int        gap_pct = 7;
   int        stall_pct = 7;

   function automatic coord_type halfway(input coord_type a, input coord_type b);
      longint sum;
      longint q;
      sum = longint'(a) + longint'(b);
      q = sum / 2;
      return q[COORD_WIDTH-1:0];
   endfunction

   function automatic coord_type out_y(input coord_type y);
      if (!flip_on) begin
         return y;
      end
      if (y == COORD_MIN) begin
         return COORD_MAX;
      end
      return -y;
   endfunction

   function automatic void add_cmd(input logic [2:0] cmd,
                                   input coord_type ax, input coord_type ay,
                                   input coord_type bx, input coord_type by,
                                   input coord_type cx, input coord_type cy);
      rsp_type r;
      r.command  = cmd;
      r.x_one    = ax;
      r.y_one    = out_y(ay);
      r.x_two    = bx;
      r.y_two    = out_y(by);
      r.x_three  = cx;
      r.y_three  = out_y(cy);
      r.run_last = 1'b0;
      step_cmds[step_count] = r;
      step_count++;
   endfunction

   function automatic void clear_contour();
      start_x = '0;
      start_y = '0;
      ctl1_x = '0;
      ctl1_y = '0;
      ctl2_x = '0;
      ctl2_y = '0;
      phase = PH_IDLE;
      skip_close = 1'b0;
      err_latched = 1'b0;
   endfunction

   // Close whatever is pending back to the contour start.
   function automatic void close_contour();
      case (phase)
         PH_OPEN: begin
            add_cmd(CMD_CLOSE, 0, 0, 0, 0, 0, 0);
         end
         PH_CONIC: begin
            add_cmd(CMD_QUAD, ctl1_x, ctl1_y, start_x, start_y, 0, 0);
         end
         PH_CUB1: begin
            step_bad = 1'b1;
         end
         PH_CUB2: begin
            add_cmd(CMD_CUBIC, ctl1_x, ctl1_y, ctl2_x, ctl2_y, start_x, start_y);
         end
         default: begin
         end
      endcase
      phase = PH_IDLE;
   endfunction

   function automatic void decompose_point(input req_type p);
      logic cend;
      int   i;
      step_count = 0;
      step_bad = 1'b0;
      cend = p.contour_end | p.outline_end;
      if (err_latched) begin
         if (p.outline_end) begin
            clear_contour();
         end
         return;
      end
      if (p.contour_first) begin
         skip_close = 1'b0;
         phase = PH_IDLE;
         if (p.point_tag[1]) begin
            step_bad = 1'b1;
         end else if (p.point_tag == TAG_ON) begin
            start_x = p.point_x;
            start_y = p.point_y;
            add_cmd(CMD_MOVE, p.point_x, p.point_y, 0, 0, 0, 0);
            phase = PH_OPEN;
            if (cend) begin
               close_contour();
            end
         end else begin
            // Conic start: begin at the closing point if on-curve, else halfway to it.
            if (p.closing_tag == TAG_ON) begin
               start_x = p.closing_x;
               start_y = p.closing_y;
               skip_close = 1'b1;
            end else begin
               start_x = halfway(p.point_x, p.closing_x);
               start_y = halfway(p.point_y, p.closing_y);
            end
            add_cmd(CMD_MOVE, start_x, start_y, 0, 0, 0, 0);
            if (skip_close && cend) begin
               phase = PH_OPEN;
            end else begin
               ctl1_x = p.point_x;
               ctl1_y = p.point_y;
               phase = PH_CONIC;
            end
            if (cend) begin
               close_contour();
            end
         end
      end else if (phase != PH_IDLE) begin
         if (!(cend && skip_close)) begin
            case (phase)
               PH_OPEN: begin
                  if (p.point_tag == TAG_ON) begin
                     add_cmd(CMD_LINE, p.point_x, p.point_y, 0, 0, 0, 0);
                  end else begin
                     ctl1_x = p.point_x;
                     ctl1_y = p.point_y;
                     phase = (p.point_tag == TAG_CONIC) ? PH_CONIC : PH_CUB1;
                  end
               end
               PH_CONIC: begin
                  if (p.point_tag == TAG_ON) begin
                     add_cmd(CMD_QUAD, ctl1_x, ctl1_y, p.point_x, p.point_y, 0, 0);
                     phase = PH_OPEN;
                  end else if (p.point_tag == TAG_CONIC) begin
                     add_cmd(CMD_QUAD, ctl1_x, ctl1_y, halfway(ctl1_x, p.point_x),
                             halfway(ctl1_y, p.point_y), 0, 0);
                     ctl1_x = p.point_x;
                     ctl1_y = p.point_y;
                  end else begin
                     step_bad = 1'b1;
                  end
               end
               PH_CUB1: begin
                  if (p.point_tag[1]) begin
                     ctl2_x = p.point_x;
                     ctl2_y = p.point_y;
                     phase = PH_CUB2;
                  end else begin
                     step_bad = 1'b1;
                  end
               end
               PH_CUB2: begin
                  // Any tag ends the cubic here.
                  add_cmd(CMD_CUBIC, ctl1_x, ctl1_y, ctl2_x, ctl2_y, p.point_x, p.point_y);
                  phase = PH_OPEN;
               end
               default: begin
               end
            endcase
         end
         if (!step_bad && cend) begin
            close_contour();
         end
      end
      if (step_bad) begin
         add_cmd(CMD_BAD, 0, 0, 0, 0, 0, 0);
         phase = PH_IDLE;
         err_latched = 1'b1;
      end
      if (cend) begin
         phase = PH_IDLE;
      end
      if (p.outline_end) begin
         err_latched = 1'b0;
         phase = PH_IDLE;
         skip_close = 1'b0;
      end
      if (step_count > 0) begin
         step_cmds[step_count-1].run_last = 1'b1;
      end
      for (i = 0; i < step_count; i++) begin
         expected_cmds.push_back(step_cmds[i]);
      end
   endfunction

   function automatic void check_field(input string field, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cmds.size() == 0) begin
            $error("command item with nothing expected: command %0d", rsp_data.command);
            fail_count++;
         end else begin
            want_cmd = expected_cmds.pop_front();
            check_field("command", want_cmd.command, rsp_data.command);
            check_field("x_one", want_cmd.x_one, rsp_data.x_one);
            check_field("y_one", want_cmd.y_one, rsp_data.y_one);
            check_field("x_two", want_cmd.x_two, rsp_data.x_two);
            check_field("y_two", want_cmd.y_two, rsp_data.y_two);
            check_field("x_three", want_cmd.x_three, rsp_data.x_three);
            check_field("y_three", want_cmd.y_three, rsp_data.y_three);
            check_field("run_last", want_cmd.run_last, rsp_data.run_last);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic coord_type rand_coord();
      coord_type v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: v = COORD_MIN;
               1: v = COORD_MAX;
               2: v = '0;
               default: v = '1;
            endcase
         end
         1, 2: v = $urandom;
         default: v = $urandom_range(2097151) - 1048576;
      endcase
      return v;
   endfunction

   function automatic logic [1:0] cubic_tag();
      return $urandom_range(1) ? TAG_CUBIC_ALT : TAG_CUBIC;
   endfunction

   function automatic req_type make_point(input coord_type x, input coord_type y,
                                          input logic [1:0] tag, input logic first,
                                          input logic cend, input logic oend,
                                          input coord_type cx, input coord_type cy,
                                          input logic [1:0] ctag);
      req_type p;
      p.point_x       = x;
      p.point_y       = y;
      p.point_tag     = tag;
      p.contour_first = first;
      p.contour_end   = cend;
      p.outline_end   = oend;
      p.closing_x     = cx;
      p.closing_y     = cy;
      p.closing_tag   = ctag;
      return p;
   endfunction

   // Called at a rising edge; returns at the edge that accepts the item.
   task automatic send_point(input req_type item);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      decompose_point(item);
      sent_points++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      // points that give no command may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_flip(input logic value);
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= REG_FLIP_VERTICAL << 2;
      pwdata <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      flip_on = value;
   endtask

   task automatic send_random_outline(input bit broken);
      coord_type  px [$];
      coord_type  py [$];
      logic [1:0] pt [$];
      int         contour_total;
      int         len;
      int         c;
      int         k;
      int         last;
      bit         drop_end;
      bit         oend_only;
      req_type    item;
      contour_total = $urandom_range(1, 3);
      oend_only = ($urandom_range(5) == 0);
      for (c = 0; c < contour_total; c++) begin
         px.delete();
         py.delete();
         pt.delete();
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
         pt.push_back($urandom_range(1) ? TAG_ON : TAG_CONIC);
         while (pt.size() < len) begin
            case ($urandom_range(3))
               0: pt.push_back(TAG_ON);
               1: pt.push_back(TAG_CONIC);
               2: begin
                  pt.push_back(cubic_tag());
                  pt.push_back(cubic_tag());
               end
               default: pt.push_back($urandom_range(1) ? TAG_ON : TAG_CONIC);
            endcase
         end
         drop_end = 1'b0;
         if (broken) begin
            pt[$urandom_range(pt.size() - 1)] = $urandom_range(3);
            drop_end = ($urandom_range(2) == 0);
            if ($urandom_range(3) == 0) begin
               // stray point outside any contour's start
               send_point(make_point(rand_coord(), rand_coord(), $urandom_range(3), 1'b0,
                                     $urandom_range(1), 1'b0, $urandom, $urandom,
                                     $urandom_range(3)));
            end
         end
         for (k = 0; k < pt.size(); k++) begin
            px.push_back(rand_coord());
            py.push_back(rand_coord());
         end
         last = pt.size() - 1;
         for (k = 0; k <= last; k++) begin
            item = make_point(px[k], py[k], pt[k], k == 0, 1'b0, 1'b0,
                              $urandom, $urandom, $urandom_range(3));
            if (k == 0) begin
               item.closing_x = px[last];
               item.closing_y = py[last];
               item.closing_tag = pt[last];
            end
            if (k == last) begin
               item.outline_end = (c == contour_total - 1);
               item.contour_end = !drop_end && !(item.outline_end && oend_only);
            end
            send_point(item);
         end
      end
   endtask

   task automatic run_random(input int count, input int broken_pct);
      int      stop_at;
      req_type item;
      stop_at = sent_points + count;
      while (sent_points < stop_at) begin
         if ($urandom_range(99) >= broken_pct) begin
            send_random_outline(1'b0);
         end else if ($urandom_range(1)) begin
            send_random_outline(1'b1);
         end else begin
            item = make_point($urandom, $urandom, $urandom_range(3),
                              $urandom_range(3) == 0, $urandom_range(3) == 0,
                              $urandom_range(7) == 0, $urandom, $urandom,
                              $urandom_range(3));
            send_point(item);
         end
      end
   endtask

   task automatic test_directed_outlines();
      // a move, a quad and close
      send_point(make_point(100, 200, TAG_ON, 1, 0, 0, 100, 400, TAG_ON));
      send_point(make_point(300, 200, TAG_CONIC, 0, 0, 0, 0, 0, 0));
      send_point(make_point(100, 400, TAG_ON, 0, 1, 0, 0, 0, 0));
      // conic start with on-curve closing point, closing point skipped
      send_point(make_point(0, 0, TAG_CONIC, 1, 0, 0, -64, -64, TAG_ON));
      send_point(make_point(64, 64, TAG_CONIC, 0, 0, 0, 0, 0, 0));
      send_point(make_point(-64, -64, TAG_ON, 0, 1, 0, 0, 0, 0));
      // conic start halfway to a conic closing point, extreme coordinates
      send_point(make_point(COORD_MAX, COORD_MIN, TAG_CONIC, 1, 0, 0,
                            COORD_MAX, COORD_MIN, TAG_CONIC));
      send_point(make_point(COORD_MIN, COORD_MAX, TAG_CONIC, 0, 0, 0, 0, 0, 0));
      send_point(make_point(-3, -5, TAG_CONIC, 0, 1, 0, 0, 0, 0));
      // cubic, any tag ends it, then a contour ending after one cubic control
      send_point(make_point(0, 0, TAG_ON, 1, 0, 0, 0, 0, 0));
      send_point(make_point(10, 10, TAG_CUBIC, 0, 0, 0, 0, 0, 0));
      send_point(make_point(20, -7, TAG_CUBIC_ALT, 0, 0, 0, 0, 0, 0));
      send_point(make_point(30, 0, TAG_CONIC, 0, 0, 0, 0, 0, 0));
      send_point(make_point(-1, 1, TAG_CUBIC, 0, 1, 1, 0, 0, 0));
      // single point contours
      send_point(make_point(5, 5, TAG_ON, 1, 1, 0, 0, 0, 0));
      send_point(make_point(-3, 7, TAG_CONIC, 1, 1, 0, 0, -2, TAG_CONIC));
      send_point(make_point(1, 1, TAG_CONIC, 1, 1, 0, 9, 9, TAG_ON));
      // contour opening on a cubic
      send_point(make_point(0, 0, TAG_CUBIC_ALT, 1, 0, 1, 0, 0, 0));
      // cubic control followed by an on-curve point
      send_point(make_point(0, 0, TAG_ON, 1, 0, 0, 0, 0, 0));
      send_point(make_point(1, 1, TAG_CUBIC, 0, 0, 0, 0, 0, 0));
      send_point(make_point(2, 2, TAG_ON, 0, 0, 1, 0, 0, 0));
      // cubic after a conic, then ignored points until the outline ends
      send_point(make_point(0, 0, TAG_ON, 1, 0, 0, 0, 0, 0));
      send_point(make_point(1, 1, TAG_CONIC, 0, 0, 0, 0, 0, 0));
      send_point(make_point(2, 2, TAG_CUBIC, 0, 0, 0, 0, 0, 0));
      send_point(make_point(3, 3, TAG_ON, 1, 0, 0, 0, 0, 0));
      send_point(make_point(4, 4, TAG_ON, 0, 0, 1, 0, 0, 0));
      // restart while open, outline end without contour end, then a stray point
      send_point(make_point(0, 0, TAG_ON, 1, 0, 0, 3, 4, TAG_ON));
      send_point(make_point(1, 2, TAG_ON, 1, 0, 0, 3, 4, TAG_ON));
      send_point(make_point(3, 4, TAG_ON, 0, 0, 1, 0, 0, 0));
      send_point(make_point(7, 7, TAG_ON, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_flip_cleared();
      write_flip(1'b0);
      run_random(200, 5);
   endtask

   task automatic test_steady_stream();
      write_flip(1'b1);
      gap_pct = 0;
      stall_pct = 0;
      run_random(150, 5);
      gap_pct = 7;
      stall_pct = 7;
   endtask

   task automatic test_drain_pause();
      run_random(50, 10);
      wait_drained();
      run_random(50, 10);
   endtask

   task automatic test_broken_outlines();
      write_flip(1'b0);
      run_random(150, 60);
   endtask

   task automatic test_flip_set_random();
      write_flip(1'b1);
      run_random(60, 10);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      flip_on = 1'b1;
      clear_contour();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_outlines();
      test_flip_cleared();
      test_steady_stream();
      test_drain_pause();
      test_broken_outlines();
      test_flip_set_random();
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_cmds.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
